FILE: hdl/std140_pkg.sv
// Package for the std140 layout offset allocator.
// Holds payload structs, op codes, controller state type and the vector table.
// No dependencies.
package std140_pkg;

   localparam int OP_W     = 3;
   localparam int KIND_W   = 3;
   localparam int COMP_W   = 3;
   localparam int CNT_W    = 16;
   localparam int ALIGN_W  = 6;
   localparam int SIZE_W   = 24;
   localparam int OFFSET_W = 24;
   localparam int STRIDE_W = SIZE_W + 1;
   localparam int NM1_W    = 18;              // up to 4 * 65535 elements
   localparam int HALF_W   = NM1_W / 2;
   localparam int PROD_W   = STRIDE_W + NM1_W;

   localparam logic [OP_W-1:0] OP_ELEMENT      = 3'd0;
   localparam logic [OP_W-1:0] OP_ARRAY        = 3'd1;
   localparam logic [OP_W-1:0] OP_MATRIX       = 3'd2;
   localparam logic [OP_W-1:0] OP_MATRIX_ARRAY = 3'd3;
   localparam logic [OP_W-1:0] OP_STRUCT       = 3'd4;
   localparam logic [OP_W-1:0] OP_STRUCT_ARRAY = 3'd5;
   localparam logic [OP_W-1:0] OP_CLEAR        = 3'd6;

   localparam logic [KIND_W-1:0] KIND_DOUBLE = 3'd4;

   localparam logic [ALIGN_W-1:0] ALIGN_16 = 6'd16;
   localparam logic [ALIGN_W-1:0] ALIGN_32 = 6'd32;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [KIND_W-1:0]  base_kind;
      logic [COMP_W-1:0]  components;
      logic [COMP_W-1:0]  rows;
      logic [COMP_W-1:0]  cols;
      logic               col_major;
      logic [CNT_W-1:0]   count;
      logic [ALIGN_W-1:0] sub_align;
      logic [SIZE_W-1:0]  sub_size;
   } req_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] offset;
      logic [SIZE_W-1:0]   total_size;
      logic [ALIGN_W-1:0]  largest_align;
      logic                overflow;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;      // capture item, set up first/stride/count
      logic mul_lo;    // low partial product
      logic mul_hi;    // high partial product, partial sum
      logic commit;    // update state, load result register
   } cmd_type;

   typedef struct packed {
      logic [ALIGN_W-1:0] align;
      logic [ALIGN_W-1:0] size;
   } vec_info_type;

   // 0 -> 2, 1 -> 2, 5..7 -> 4
   function automatic logic [COMP_W-1:0] clamp_dim(input logic [COMP_W-1:0] v);
      logic [COMP_W-1:0] r;
      r = v;
      if (v inside {3'd0, 3'd1}) r = 3'd2;
      else if (v inside {[3'd5:3'd7]}) r = 3'd4;
      return r;
   endfunction

   function automatic vec_info_type vec_info(input logic [KIND_W-1:0] kind,
                                             input logic [COMP_W-1:0] comps);
      vec_info_type r;
      logic [COMP_W-1:0] c;
      c = comps;
      if (comps == 3'd0) c = 3'd1;
      else if (comps inside {[3'd5:3'd7]}) c = 3'd4;
      if (kind == KIND_DOUBLE) begin
         case (c)
            3'd1:    r = '{align: 6'd8,  size: 6'd8};
            3'd2:    r = '{align: 6'd16, size: 6'd16};
            default: r = '{align: 6'd32, size: 6'd32};
         endcase
      end else begin
         case (c)
            3'd1:    r = '{align: 6'd4,  size: 6'd4};
            3'd2:    r = '{align: 6'd8,  size: 6'd8};
            3'd3:    r = '{align: 6'd16, size: 6'd12};
            default: r = '{align: 6'd16, size: 6'd16};
         endcase
      end
      return r;
   endfunction

endpackage

FILE: hdl/std140_ctrl.sv
// Controller for the std140 layout offset allocator.
// Sequences accept, two multiply steps and commit; owns the result valid flag.
// Depends on std140_pkg.
module std140_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output std140_pkg::cmd_type cmd
);
   import std140_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_MUL_LO;
         ST_MUL_LO: state_in = ST_MUL_HI;
         ST_MUL_HI: state_in = ST_DONE;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_MUL_LO: cmd.mul_lo = 1'b1;
         ST_MUL_HI: cmd.mul_hi = 1'b1;
         ST_DONE:   cmd.commit = out_free;
         default:   cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hdl/std140_dpath.sv
// Datapath for the std140 layout offset allocator.
// Decode, alignment, split stride multiply, overflow check, layout state, result reg.
// Depends on std140_pkg.
module std140_dpath #(
   parameter int ADDR_BITS = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  std140_pkg::cmd_type cmd,
   input  std140_pkg::req_type req_payload,
   output std140_pkg::rsp_type rsp_payload
);
   import std140_pkg::*;

   localparam int FIRST_W = ADDR_BITS + 1;
   localparam int END_W   = ((FIRST_W > PROD_W) ? FIRST_W : PROD_W) + 2;
   localparam int PLO_W   = STRIDE_W + HALF_W;

   // setup (combinational from the incoming item)
   vec_info_type       vinfo;
   logic [COMP_W-1:0]  rows_c, cols_c, vcomp, nvec;
   logic [ALIGN_W-1:0] sal, al;
   logic [SIZE_W-1:0]  sz;
   logic [CNT_W-1:0]   cnt_nz;
   logic [COMP_W-1:0]  mul_a;
   logic [CNT_W-1:0]   mul_b;
   logic [NM1_W-1:0]   n_elems;
   logic [FIRST_W-1:0] al_m1_f, first;
   logic [STRIDE_W-1:0] al_m1_s, stride;

   // working registers
   logic [OP_W-1:0]     op_ff;
   logic [ALIGN_W-1:0]  al_ff;
   logic [SIZE_W-1:0]   sz_ff;
   logic [FIRST_W-1:0]  first_ff;
   logic [STRIDE_W-1:0] stride_ff;
   logic [NM1_W-1:0]    nm1_ff;
   logic [PLO_W-1:0]    p_lo_ff, p_hi_ff;
   logic [END_W-1:0]    base_ff;

   // layout state
   logic [ADDR_BITS-1:0] cursor_ff, cursor_in;
   logic [ALIGN_W-1:0]   max_align_ff, max_align_in;
   rsp_type              rsp_ff, rsp_in;

   // commit-stage signals
   logic [END_W-1:0]     end_sum;
   logic                 ovf;
   logic [ADDR_BITS-1:0] first_sat;
   logic [ALIGN_W-1:0]   max_new;

   always_comb begin
      rows_c = clamp_dim(req_payload.rows);
      cols_c = clamp_dim(req_payload.cols);
      vcomp  = req_payload.components;
      nvec   = 3'd1;
      if (req_payload.op == OP_MATRIX || req_payload.op == OP_MATRIX_ARRAY) begin
         vcomp = req_payload.col_major ? rows_c : cols_c;
         nvec  = req_payload.col_major ? cols_c : rows_c;
      end
      vinfo = vec_info(req_payload.base_kind, vcomp);

      sal = req_payload.sub_align;
      if (sal == '0) sal = ALIGN_16;
      else if (sal > ALIGN_32) sal = ALIGN_32;

      cnt_nz = (req_payload.count == '0) ? CNT_W'(1) : req_payload.count;

      al    = vinfo.align;
      sz    = SIZE_W'(vinfo.size);
      mul_a = 3'd1;
      mul_b = CNT_W'(1);
      case (req_payload.op)
         OP_ELEMENT: ;
         OP_ARRAY: begin
            if (al < ALIGN_16) al = ALIGN_16;
            mul_b = cnt_nz;
         end
         OP_MATRIX: begin
            if (al < ALIGN_16) al = ALIGN_16;
            mul_a = nvec;
         end
         OP_MATRIX_ARRAY: begin
            if (al < ALIGN_16) al = ALIGN_16;
            mul_a = nvec;
            mul_b = cnt_nz;
         end
         OP_STRUCT, OP_STRUCT_ARRAY: begin
            al = (sal > ALIGN_16) ? ALIGN_32 : ALIGN_16;
            sz = req_payload.sub_size;
            if (req_payload.op == OP_STRUCT_ARRAY) mul_b = cnt_nz;
         end
         default: ;
      endcase

      n_elems = NM1_W'(mul_a) * NM1_W'(mul_b);
      al_m1_f = FIRST_W'(al - 6'd1);
      al_m1_s = STRIDE_W'(al - 6'd1);
      first   = (FIRST_W'(cursor_ff) + al_m1_f) & ~al_m1_f;
      stride  = (STRIDE_W'(sz) + al_m1_s) & ~al_m1_s;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_payload.op;
         al_ff     <= al;
         sz_ff     <= sz;
         first_ff  <= first;
         stride_ff <= stride;
         nm1_ff    <= n_elems - NM1_W'(1);
      end
      if (cmd.mul_lo) p_lo_ff <= PLO_W'(stride_ff) * PLO_W'(nm1_ff[HALF_W-1:0]);
      if (cmd.mul_hi) begin
         p_hi_ff <= PLO_W'(stride_ff) * PLO_W'(nm1_ff[NM1_W-1:HALF_W]);
         base_ff <= END_W'(first_ff) + END_W'(sz_ff) + END_W'(p_lo_ff);
      end
   end

   // end of member and overflow against 2^ADDR_BITS - 1
   always_comb begin
      end_sum   = base_ff + (END_W'(p_hi_ff) << HALF_W);
      ovf       = |end_sum[END_W-1:ADDR_BITS];
      first_sat = first_ff[ADDR_BITS] ? {ADDR_BITS{1'b1}} : first_ff[ADDR_BITS-1:0];
      max_new   = (al_ff > max_align_ff) ? al_ff : max_align_ff;

      cursor_in    = cursor_ff;
      max_align_in = max_align_ff;
      rsp_in       = rsp_ff;
      if (cmd.commit) begin
         if (op_ff == OP_CLEAR) begin
            cursor_in    = '0;
            max_align_in = '0;
            rsp_in       = '0;
         end else if (op_ff inside {[OP_ELEMENT:OP_STRUCT_ARRAY]}) begin
            cursor_in    = ovf ? {ADDR_BITS{1'b1}} : end_sum[ADDR_BITS-1:0];
            max_align_in = max_new;
            rsp_in.offset        = OFFSET_W'(first_sat);
            rsp_in.total_size    = SIZE_W'(cursor_in);
            rsp_in.largest_align = max_new;
            rsp_in.overflow      = ovf;
         end else begin
            rsp_in.offset        = OFFSET_W'(cursor_ff);
            rsp_in.total_size    = SIZE_W'(cursor_ff);
            rsp_in.largest_align = max_align_ff;
            rsp_in.overflow      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff    <= '0;
         max_align_ff <= '0;
      end else begin
         cursor_ff    <= cursor_in;
         max_align_ff <= max_align_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

endmodule

FILE: hdl/std140_layout_offset_allocator_core.sv
// Top level of the std140 layout offset allocator.
// Instantiates std140_ctrl and std140_dpath; depends on std140_pkg.
//
// Usage:
//   req channel (req_valid/req_ready/req_payload) takes one member request:
//   element, array, matrix, matrix array, struct, struct array, or a clear.
//   rsp channel (rsp_valid/rsp_ready/rsp_payload) returns exactly one item
//   per request: the member's first offset, the running layout size, the
//   largest alignment so far and an overflow flag (end past 2^ADDR_BITS-1,
//   cursor saturated; not sticky).
// Timing:
//   req_ready is high only while the controller is idle. After acceptance
//   the item goes through the low partial product of (elements-1)*stride,
//   then the high partial product with a partial sum, then the final add
//   and commit; a new item is taken only once the last one has committed.
//   The result is registered. The 25x18 multiply is split in two 9-bit
//   halves.
// Stall: the result register holds while rsp_ready is low; a following item
//   may be accepted and worked on, and waits in its commit cycle until the
//   register frees.
// Reset: synchronous, active high; cursor and largest alignment go to 0,
//   no result pending, ready for an item in the next cycle.
module std140_layout_offset_allocator_core #(
   parameter int ADDR_BITS = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  std140_pkg::req_type req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output std140_pkg::rsp_type rsp_payload
);
   import std140_pkg::*;

   cmd_type cmd;

   // sequencing and handshakes
   std140_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // layout arithmetic and state
   std140_dpath #(
      .ADDR_BITS (ADDR_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: verif/std140_layout_checker.sv
`timescale 1ns / 1ps
// Checker for std140_layout_offset_allocator_core: predicts each member placement
// from the accepted requests and compares it with the rsp channel. Needs std140_pkg.
module std140_layout_checker #(
   parameter int ADDR_BITS = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  std140_pkg::req_type req_payload,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  std140_pkg::rsp_type rsp_payload,
   output int                  fail_count,
   output int                  pending
);
   import std140_pkg::*;

   localparam longint unsigned ADDR_LIMIT = (64'd1 << ADDR_BITS) - 64'd1;
   localparam int REPORT_MAX = 10;

   // predicted layout state
   logic [ADDR_BITS-1:0] layout_end;
   logic [ALIGN_W-1:0]   layout_align;

   rsp_type predicted_members[$];

   function automatic longint unsigned round_up(input longint unsigned v,
                                                input longint unsigned a);
      return (v + a - 64'd1) & ~(a - 64'd1);
   endfunction

   function automatic logic [COMP_W-1:0] dim_clamp(input logic [COMP_W-1:0] v);
      if (v < 3'd2) return 3'd2;
      if (v > 3'd4) return 3'd4;
      return v;
   endfunction

   function automatic void vector_shape(input logic [KIND_W-1:0] kind,
                                        input logic [COMP_W-1:0] comps,
                                        output longint unsigned al,
                                        output longint unsigned sz);
      logic [COMP_W-1:0] c;
      c = comps;
      if (comps == 3'd0) c = 3'd1;
      else if (comps > 3'd4) c = 3'd4;
      if (kind == KIND_DOUBLE) begin
         case (c)
            3'd1: begin
               al = 8;
               sz = 8;
            end
            3'd2: begin
               al = 16;
               sz = 16;
            end
            default: begin
               al = 32;
               sz = 32;
            end
         endcase
      end else begin
         sz = c * 4;
         al = (c == 3'd1) ? 4 : (c == 3'd2) ? 8 : 16;
      end
   endfunction

   // Places one member (or clears) and returns the expected result item.
   function automatic rsp_type place_member(input req_type r);
      longint unsigned al, sz, n, cnt, sal, first, stride, stop;
      logic [COMP_W-1:0] rows, cols, vcomp;
      logic do_place, ovf;
      rsp_type res;
      res = '0;
      do_place = 1'b1;
      al = 4;
      sz = 4;
      n = 1;
      cnt = (r.count == '0) ? 64'd1 : 64'(r.count);
      rows = dim_clamp(r.rows);
      cols = dim_clamp(r.cols);
      case (r.op)
         OP_ELEMENT: vector_shape(r.base_kind, r.components, al, sz);
         OP_ARRAY: begin
            vector_shape(r.base_kind, r.components, al, sz);
            if (al < 16) al = 16;
            n = cnt;
         end
         OP_MATRIX, OP_MATRIX_ARRAY: begin
            vcomp = r.col_major ? rows : cols;
            n = r.col_major ? cols : rows;
            if (r.op == OP_MATRIX_ARRAY) n = n * cnt;
            vector_shape(r.base_kind, vcomp, al, sz);
            if (al < 16) al = 16;
         end
         OP_STRUCT, OP_STRUCT_ARRAY: begin
            sal = r.sub_align;
            if (sal == 0) sal = 16;
            if (sal > 32) sal = 32;
            al = ((sal + 15) / 16) * 16;
            sz = r.sub_size;
            n = (r.op == OP_STRUCT_ARRAY) ? cnt : 1;
         end
         OP_CLEAR: begin
            layout_end = '0;
            layout_align = '0;
            do_place = 1'b0;
         end
         default: begin
            // unused op: report the state, change nothing
            do_place = 1'b0;
            res.offset = OFFSET_W'(layout_end);
            res.total_size = SIZE_W'(layout_end);
            res.largest_align = layout_align;
         end
      endcase
      if (do_place) begin
         if (al > layout_align) layout_align = ALIGN_W'(al);
         first = round_up(64'(layout_end), al);
         stride = round_up(sz, al);
         stop = first + (n - 1) * stride + sz;
         ovf = 1'b0;
         if (stop > ADDR_LIMIT) begin
            ovf = 1'b1;
            stop = ADDR_LIMIT;
            if (first > ADDR_LIMIT) first = ADDR_LIMIT;
         end
         layout_end = ADDR_BITS'(stop);
         res.offset = first[OFFSET_W-1:0];
         res.total_size = stop[SIZE_W-1:0];
         res.largest_align = layout_align;
         res.overflow = ovf;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         layout_end = '0;
         layout_align = '0;
         predicted_members.delete();
         fail_count = 0;
      end else begin
         // results first, so a stray item is never matched to this edge's request
         if (rsp_valid && rsp_ready) begin
            if (predicted_members.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("unexpected result item: offset %0d size %0d align %0d ovf %0b",
                           rsp_payload.offset, rsp_payload.total_size,
                           rsp_payload.largest_align, rsp_payload.overflow);
            end else begin
               want = predicted_members.pop_front();
               if (rsp_payload.offset !== want.offset
                   || rsp_payload.total_size !== want.total_size
                   || rsp_payload.largest_align !== want.largest_align
                   || rsp_payload.overflow !== want.overflow) begin
                  fail_count++;
                  if (fail_count <= REPORT_MAX)
                     $display("mismatch exp/act: offset %0d/%0d size %0d/%0d %s",
                              want.offset, rsp_payload.offset,
                              want.total_size, rsp_payload.total_size,
                              $sformatf("align %0d/%0d ovf %0b/%0b",
                                        want.largest_align, rsp_payload.largest_align,
                                        want.overflow, rsp_payload.overflow));
               end
            end
         end
         if (req_valid && req_ready)
            predicted_members.push_back(place_member(req_payload));
      end
      pending = predicted_members.size();
   end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Testbench top for std140_layout_offset_allocator_core: makes member requests,
// idles both channels and gives the verdict. Needs std140_pkg, std140_layout_checker.
module testbench;
   import std140_pkg::*;

   // op 7 has no package name; the block reports state and does nothing else
   localparam logic [OP_W-1:0]   OP_UNUSED  = 3'd7;
   localparam logic [KIND_W-1:0] KIND_BOOL  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INT   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_UINT  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FLOAT = 3'd3;
   localparam logic [KIND_W-1:0] KIND_WILD  = 3'd7;   // past double, acts as 4-byte

   localparam int ADDR_BITS        = 24;
   localparam int RANDOM_PER_PHASE = 550;
   // cycles without any item moving; far above the longest random idle run
   localparam int QUIET_LIMIT      = 2000;
   localparam int DRAIN_CYCLES     = 8;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   // idle odds in percent, changed per phase
   int send_idle = 37;
   int recv_idle = 58;

   int fail_count;
   int pending;
   int quiet_cycles = 0;

   std140_layout_offset_allocator_core #(
      .ADDR_BITS(ADDR_BITS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   std140_layout_checker #(
      .ADDR_BITS(ADDR_BITS)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Receiver: ready is redrawn every falling edge, so stalls land on any phase
   // of the block's work, including its held commit cycle.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   // Watchdog: count edges at which no item moved on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   function automatic req_type member(input logic [OP_W-1:0]    op,
                                      input logic [KIND_W-1:0]  kind,
                                      input logic [COMP_W-1:0]  comps,
                                      input logic [COMP_W-1:0]  rows,
                                      input logic [COMP_W-1:0]  cols,
                                      input logic               cm,
                                      input logic [CNT_W-1:0]   cnt,
                                      input logic [ALIGN_W-1:0] sal,
                                      input logic [SIZE_W-1:0]  ssz);
      req_type r;
      r.op = op;
      r.base_kind = kind;
      r.components = comps;
      r.rows = rows;
      r.cols = cols;
      r.col_major = cm;
      r.count = cnt;
      r.sub_align = sal;
      r.sub_size = ssz;
      return r;
   endfunction

   // Mostly well-formed members with small counts and sizes, so layouts grow
   // for a while before saturating; a few large counts/sizes force overflow,
   // and a slice of raw noise covers every bit of every field.
   function automatic req_type random_member();
      req_type r;
      logic [63:0] raw;
      raw = {$urandom(), $urandom()};
      if ($urandom_range(99) < 8) return raw[$bits(req_type)-1:0];
      r = raw[$bits(req_type)-1:0];
      r.op = OP_W'($urandom_range(OP_STRUCT_ARRAY));
      r.base_kind = KIND_W'($urandom_range(KIND_DOUBLE));
      r.components = COMP_W'($urandom_range(4, 1));
      r.rows = COMP_W'($urandom_range(4, 2));
      r.cols = COMP_W'($urandom_range(4, 2));
      r.count = ($urandom_range(9) == 0) ? CNT_W'($urandom_range(16'hFFFF, 1))
                                         : CNT_W'($urandom_range(8, 1));
      if ($urandom_range(3) == 0)
         r.sub_align = ALIGN_W'($urandom_range(32, 1));
      else
         r.sub_align = 6'd1 << $urandom_range(5, 2);
      r.sub_size = ($urandom_range(19) == 0) ? SIZE_W'($urandom_range(24'hFFFFFF))
                                             : SIZE_W'($urandom_range(512));
      return r;
   endfunction

   // Drive one request item. Called right after an accepting edge (or reset),
   // so valid either stays high into the next item or drops for an idle gap.
   task automatic send_member(input req_type r);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin
      int layout_left;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: every op, table corners, clamps of out-of-range fields,
      // zero and oversized struct alignment, zero count, overflow and the
      // saturated-cursor case, then the unused op.
      send_member(member(OP_CLEAR, KIND_BOOL, 1, 2, 2, 0, 1, 0, 0));
      send_member(member(OP_ELEMENT, KIND_BOOL, 1, 2, 2, 0, 1, 0, 0));
      send_member(member(OP_ELEMENT, KIND_INT, 2, 2, 2, 0, 1, 0, 0));
      send_member(member(OP_ELEMENT, KIND_UINT, 3, 2, 2, 0, 1, 0, 0));
      send_member(member(OP_ELEMENT, KIND_FLOAT, 4, 2, 2, 0, 1, 0, 0));
      send_member(member(OP_ELEMENT, KIND_DOUBLE, 1, 2, 2, 0, 1, 0, 0));
      send_member(member(OP_ELEMENT, KIND_DOUBLE, 3, 2, 2, 0, 1, 0, 0));
      send_member(member(OP_ELEMENT, KIND_WILD, 0, 2, 2, 0, 1, 0, 0));
      send_member(member(OP_ELEMENT, KIND_DOUBLE, 7, 2, 2, 0, 1, 0, 0));
      send_member(member(OP_ARRAY, KIND_FLOAT, 3, 2, 2, 0, 0, 0, 0));
      send_member(member(OP_ARRAY, KIND_DOUBLE, 2, 2, 2, 0, 5, 0, 0));
      send_member(member(OP_MATRIX, KIND_FLOAT, 1, 3, 4, 1, 1, 0, 0));
      send_member(member(OP_MATRIX, KIND_FLOAT, 1, 3, 4, 0, 1, 0, 0));
      send_member(member(OP_MATRIX, KIND_DOUBLE, 1, 0, 7, 1, 1, 0, 0));
      send_member(member(OP_MATRIX_ARRAY, KIND_DOUBLE, 1, 4, 1, 0, 3, 0, 0));
      send_member(member(OP_STRUCT, KIND_BOOL, 1, 2, 2, 0, 1, 0, 20));
      send_member(member(OP_STRUCT, KIND_BOOL, 1, 2, 2, 0, 1, 6'd63, 0));
      send_member(member(OP_STRUCT, KIND_BOOL, 1, 2, 2, 0, 1, 17, 40));
      send_member(member(OP_STRUCT_ARRAY, KIND_BOOL, 1, 2, 2, 0, 7, 8, 100));
      send_member(member(OP_UNUSED, KIND_BOOL, 1, 2, 2, 0, 1, 0, 0));
      send_member(member(OP_CLEAR, KIND_BOOL, 1, 2, 2, 0, 1, 0, 0));
      // largest struct array runs far past the address limit
      send_member(member(OP_STRUCT_ARRAY, KIND_BOOL, 1, 2, 2, 0, 16'hFFFF, 32,
                         24'hFFFFFF));
      // cursor sits at the limit: the aligned start is past it and saturates too
      send_member(member(OP_ELEMENT, KIND_BOOL, 1, 2, 2, 0, 1, 0, 0));
      send_member(member(OP_UNUSED, KIND_BOOL, 1, 2, 2, 0, 1, 0, 0));
      send_member(member(OP_CLEAR, KIND_BOOL, 1, 2, 2, 0, 1, 0, 0));

      // Random: layouts of random length; within a phase each is closed by a clear, but a phase may end mid-layout.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle = 37;
               recv_idle = 58;
            end
            1: begin
               send_idle = 58;
               recv_idle = 37;
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
            end
         endcase
         layout_left = $urandom_range(40, 4);
         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            if (layout_left == 0) begin
               send_member(member(OP_CLEAR, KIND_BOOL, 1, 2, 2, 0, 1, 0, 0));
               layout_left = $urandom_range(40, 4);
            end else begin
               send_member(random_member());
               layout_left--;
            end
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;

      // drain: every expected item in, then wait for anything stray
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: files.f
hdl/std140_pkg.sv
hdl/std140_ctrl.sv
hdl/std140_dpath.sv
hdl/std140_layout_offset_allocator_core.sv
verif/std140_layout_checker.sv
verif/testbench.sv
